// File: hw/rtl/kfpv_pkg.sv
`default_nettype none
package kfpv_pkg;

    localparam int STATE_COUNT = 6;
    localparam int MEAS_COUNT  = 3;
    localparam int FRAC_BITS   = 16;

    typedef logic signed [31:0] t_word;

    localparam t_word ONE_FX = t_word'(1) <<< FRAC_BITS;

    // scratch memory
    localparam int RAM_DEPTH = 256;
    localparam int RAM_AW    = 8;
    localparam int CNT_W     = 3;

    // divider: numerator is |num| << FRAC_BITS plus half the divisor
    localparam int DIV_NW = 32 + FRAC_BITS;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    // memory map
    localparam logic [RAM_AW-1:0] A_EST  = 8'd0;
    localparam logic [RAM_AW-1:0] A_P    = 8'd8;
    localparam logic [RAM_AW-1:0] A_T1   = 8'd44;
    localparam logic [RAM_AW-1:0] A_T2   = 8'd80;
    localparam logic [RAM_AW-1:0] A_HX   = 8'd116;
    localparam logic [RAM_AW-1:0] A_INN  = 8'd120;
    localparam logic [RAM_AW-1:0] A_S    = 8'd124;
    localparam logic [RAM_AW-1:0] A_S2   = 8'd133;
    localparam logic [RAM_AW-1:0] A_COF  = 8'd142;
    localparam logic [RAM_AW-1:0] A_DET  = 8'd151;
    localparam logic [RAM_AW-1:0] A_SINV = 8'd152;
    localparam logic [RAM_AW-1:0] A_PHT  = 8'd161;
    localparam logic [RAM_AW-1:0] A_K    = 8'd179;
    localparam logic [RAM_AW-1:0] A_DX   = 8'd197;

    // commands, status, register indexes
    localparam logic [1:0] CMD_INIT    = 2'd0;
    localparam logic [1:0] CMD_PREDICT = 2'd1;
    localparam logic [1:0] CMD_UPDATE  = 2'd2;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_READY = 2'd1;
    localparam logic [1:0] ST_SINGULAR  = 2'd2;

    localparam logic [1:0] REG_INIT_COV   = 2'd0;
    localparam logic [1:0] REG_PROC_NOISE = 2'd1;
    localparam logic [1:0] REG_MEAS_NOISE = 2'd2;

    localparam logic [30:0] CFG_INIT_COV_RST   = 31'd655360;
    localparam logic [30:0] CFG_PROC_NOISE_RST = 31'd65536;
    localparam logic [30:0] CFG_MEAS_NOISE_RST = 31'd6554;

    // program entry points
    localparam logic [4:0] PC_INIT    = 5'd0;
    localparam logic [4:0] PC_PREDICT = 5'd3;
    localparam logic [4:0] PC_UPDATE  = 5'd9;

    typedef enum logic [3:0] {
        SRC_MEM, SRC_ZERO, SRC_AMAT, SRC_HMAT, SRC_IDENT,
        SRC_QDIAG, SRC_RDIAG, SRC_P0DIAG, SRC_Z
    } t_src;

    typedef enum logic [2:0] {
        K_MUL, K_ADD, K_SUB, K_COF, K_DIV, K_JZ, K_END
    } t_kind;

    typedef struct packed {
        t_src              src;
        logic [RAM_AW-1:0] base;
        logic [2:0]        ld;
        logic              tr;
    } t_opnd;

    typedef struct packed {
        t_kind             kind;
        logic [CNT_W-1:0]  n;
        logic [CNT_W-1:0]  m;
        logic [CNT_W-1:0]  p;
        t_opnd             a;
        t_opnd             b;
        logic [RAM_AW-1:0] cbase;
        logic [2:0]        cld;
        logic              det;
    } t_uword;

    typedef struct packed {
        logic              valid;
        logic              a_mem;
        logic              b_mem;
        logic [RAM_AW-1:0] a_addr;
        logic [RAM_AW-1:0] b_addr;
        t_word             a_const;
        t_word             b_const;
        logic              mul;
        logic              sub;
        logic              neg;
        logic              first;
        logic              last;
        logic              div;
        logic              det;
        logic [RAM_AW-1:0] waddr;
    } t_issue;

    typedef struct packed {
        logic empty;
        logic div_done;
        logic det_zero;
    } t_dp_stat;

    typedef struct packed {
        logic [1:0]                  cmd;
        logic [30:0]                 dt;
        logic [MEAS_COUNT-1:0][31:0] z;
    } t_cmd;

    typedef struct packed {
        logic [30:0] init_cov;
        logic [30:0] proc_noise;
        logic [30:0] meas_noise;
    } t_cfg;

    function automatic t_uword uw(
        t_kind kind, int n, int m, int p,
        t_src as, logic [RAM_AW-1:0] ab, int al, logic at,
        t_src bs, logic [RAM_AW-1:0] bb, int bl, logic bt,
        logic [RAM_AW-1:0] cb, int cl, logic det
    );
        t_uword w;
        w.kind   = kind;
        w.n      = CNT_W'(n);
        w.m      = CNT_W'(m);
        w.p      = CNT_W'(p);
        w.a.src  = as;
        w.a.base = ab;
        w.a.ld   = 3'(al);
        w.a.tr   = at;
        w.b.src  = bs;
        w.b.base = bb;
        w.b.ld   = 3'(bl);
        w.b.tr   = bt;
        w.cbase  = cb;
        w.cld    = 3'(cl);
        w.det    = det;
        return w;
    endfunction

    // microprogram
    function automatic t_uword rom(logic [4:0] pc);
        t_uword w;
        case (pc)
            // init: clear estimate, P = diag(initial covariance)
            5'd0:  w = uw(K_ADD, 1, 1, 6, SRC_ZERO, 0, 0, 0, SRC_ZERO, 0, 0, 0, A_EST, 6, 0);
            5'd1:  w = uw(K_ADD, 6, 1, 6, SRC_P0DIAG, 0, 0, 0, SRC_ZERO, 0, 0, 0, A_P, 6, 0);
            5'd2:  w = uw(K_END, 0, 0, 0, SRC_ZERO, 0, 0, 0, SRC_ZERO, 0, 0, 0, 0, 0, 0);
            // predict
            5'd3:  w = uw(K_MUL, 6, 6, 1, SRC_AMAT, 0, 0, 0, SRC_MEM, A_EST, 1, 0, A_T1, 1, 0);
            5'd4:  w = uw(K_ADD, 6, 1, 1, SRC_MEM, A_T1, 1, 0, SRC_ZERO, 0, 0, 0, A_EST, 1, 0);
            5'd5:  w = uw(K_MUL, 6, 6, 6, SRC_AMAT, 0, 0, 0, SRC_MEM, A_P, 6, 0, A_T1, 6, 0);
            5'd6:  w = uw(K_MUL, 6, 6, 6, SRC_MEM, A_T1, 6, 0, SRC_AMAT, 0, 0, 1, A_T2, 6, 0);
            5'd7:  w = uw(K_ADD, 6, 1, 6, SRC_MEM, A_T2, 6, 0, SRC_QDIAG, 0, 0, 0, A_P, 6, 0);
            5'd8:  w = uw(K_END, 0, 0, 0, SRC_ZERO, 0, 0, 0, SRC_ZERO, 0, 0, 0, 0, 0, 0);
            // update
            5'd9:  w = uw(K_MUL, 3, 6, 1, SRC_HMAT, 0, 0, 0, SRC_MEM, A_EST, 1, 0, A_HX, 1, 0);
            5'd10: w = uw(K_SUB, 3, 1, 1, SRC_Z, 0, 0, 0, SRC_MEM, A_HX, 1, 0, A_INN, 1, 0);
            5'd11: w = uw(K_MUL, 3, 6, 6, SRC_HMAT, 0, 0, 0, SRC_MEM, A_P, 6, 0, A_T1, 6, 0);
            5'd12: w = uw(K_MUL, 3, 6, 3, SRC_MEM, A_T1, 6, 0, SRC_HMAT, 0, 0, 1, A_S, 3, 0);
            5'd13: w = uw(K_ADD, 3, 1, 3, SRC_MEM, A_S, 3, 0, SRC_RDIAG, 0, 0, 0, A_S2, 3, 0);
            5'd14: w = uw(K_COF, 3, 2, 3, SRC_MEM, A_S2, 3, 0, SRC_MEM, A_S2, 3, 0, A_COF, 3, 0);
            5'd15: w = uw(K_MUL, 1, 3, 1, SRC_MEM, A_S2, 3, 0, SRC_MEM, A_COF, 3, 1, A_DET, 1, 1);
            5'd16: w = uw(K_JZ, 0, 0, 0, SRC_ZERO, 0, 0, 0, SRC_ZERO, 0, 0, 0, 0, 0, 0);
            // divisor is the determinant held in the datapath
            5'd17: w = uw(K_DIV, 3, 1, 3, SRC_MEM, A_COF, 3, 1, SRC_ZERO, 0, 0, 0, A_SINV, 3, 0);
            5'd18: w = uw(K_MUL, 6, 6, 3, SRC_MEM, A_P, 6, 0, SRC_HMAT, 0, 0, 1, A_PHT, 3, 0);
            5'd19: w = uw(K_MUL, 6, 3, 3, SRC_MEM, A_PHT, 3, 0, SRC_MEM, A_SINV, 3, 0, A_K, 3, 0);
            5'd20: w = uw(K_MUL, 6, 3, 1, SRC_MEM, A_K, 3, 0, SRC_MEM, A_INN, 1, 0, A_DX, 1, 0);
            5'd21: w = uw(K_ADD, 6, 1, 1, SRC_MEM, A_EST, 1, 0, SRC_MEM, A_DX, 1, 0, A_EST, 1, 0);
            5'd22: w = uw(K_MUL, 6, 3, 6, SRC_MEM, A_K, 3, 0, SRC_HMAT, 0, 0, 0, A_T1, 6, 0);
            5'd23: w = uw(K_SUB, 6, 1, 6, SRC_IDENT, 0, 0, 0, SRC_MEM, A_T1, 6, 0, A_T2, 6, 0);
            5'd24: w = uw(K_MUL, 6, 6, 6, SRC_MEM, A_T2, 6, 0, SRC_MEM, A_P, 6, 0, A_T1, 6, 0);
            5'd25: w = uw(K_ADD, 6, 1, 6, SRC_MEM, A_T1, 6, 0, SRC_ZERO, 0, 0, 0, A_P, 6, 0);
            default: w = uw(K_END, 0, 0, 0, SRC_ZERO, 0, 0, 0, SRC_ZERO, 0, 0, 0, 0, 0, 0);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/kfpv_in_if.sv
`default_nettype none
interface kfpv_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [30:0]        dt;
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
    logic signed [31:0] meas_omega;

    modport source (output valid, cmd, dt, meas_x, meas_y, meas_omega, input ready);
    modport sink   (input valid, cmd, dt, meas_x, meas_y, meas_omega, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/kfpv_out_if.sv
`default_nettype none
interface kfpv_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic signed [31:0] est_theta;
    logic signed [31:0] est_vx;
    logic signed [31:0] est_vy;
    logic signed [31:0] est_omega;

    modport source (output valid, status, est_x, est_y, est_theta, est_vx, est_vy, est_omega,
                    input ready);
    modport sink   (input valid, status, est_x, est_y, est_theta, est_vx, est_vy, est_omega,
                    output ready);
endinterface
`default_nettype wire

// File: hw/rtl/kfpv_cfg_if.sv
`default_nettype none
interface kfpv_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [30:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/kfpv_ram.sv
`default_nettype none
module kfpv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end
endmodule
`default_nettype wire

// File: hw/rtl/kfpv_div.sv
`default_nettype none
module kfpv_div
    import kfpv_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_word i_num,
    input  wire t_word i_den,
    output logic       o_done,
    output t_word      o_q
);
    logic [DIV_NW-1:0] r_n;
    logic [31:0]       r_d;
    logic [31:0]       r_rem;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_neg;
    logic              r_busy;
    logic              r_done;

    logic [31:0]       mag_n;
    logic [31:0]       mag_d;
    logic [32:0]       rs;
    logic              ge;
    logic              ovf;

    assign mag_n = i_num[31] ? 32'(-i_num) : 32'(i_num);
    assign mag_d = i_den[31] ? 32'(-i_den) : 32'(i_den);
    assign rs    = {r_rem, r_n[DIV_NW-1]};
    assign ge    = rs >= {1'b0, r_d};
    assign ovf   = |r_n[DIV_NW-1:31];

    always_comb begin
        if (r_neg) begin
            o_q = ovf ? t_word'(32'h8000_0000) : t_word'(-r_n[31:0]);
        end else begin
            o_q = ovf ? t_word'(32'h7fff_ffff) : t_word'(r_n[31:0]);
        end
    end

    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_n    <= (DIV_NW'(mag_n) << FRAC_BITS) + DIV_NW'(mag_d >> 1);
                r_d    <= mag_d;
                r_rem  <= '0;
                r_neg  <= i_num[31] ^ i_den[31];
                r_cnt  <= DIV_CW'(DIV_NW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? 32'(rs - {1'b0, r_d}) : rs[31:0];
                r_n   <= {r_n[DIV_NW-2:0], ge};
                r_cnt <= r_cnt - DIV_CW'(1);
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/kfpv_dp.sv
`default_nettype none
module kfpv_dp
    import kfpv_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_issue i_iss,
    output t_dp_stat    o_stat,
    output t_word       o_est [STATE_COUNT]
);
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] MAXV = 64'sd2147483647;
    localparam logic signed [63:0] MINV = -64'sd2147483648;

    t_issue             r1;
    logic [31:0]        rd_a;
    logic [31:0]        rd_b;
    t_word              a_val;
    t_word              b_val;
    logic signed [63:0] a64;
    logic signed [63:0] b64;
    logic signed [63:0] n_p;

    logic               r2_valid;
    logic signed [63:0] r2_p;
    logic               r2_mul;
    logic               r2_neg;
    logic               r2_first;
    logic               r2_last;
    logic               r2_det;
    logic [RAM_AW-1:0]  r2_waddr;

    logic signed [63:0] term;
    logic signed [63:0] acc;
    logic signed [63:0] r_acc;
    t_word              sat;

    logic               div_done;
    t_word              div_q;
    logic [RAM_AW-1:0]  r_dwaddr;
    t_word              r_det;

    logic               we;
    logic [RAM_AW-1:0]  wa;
    t_word              wd;

    logic               r_det_zero;
    t_word              r_est [STATE_COUNT];

    kfpv_ram #(.WIDTH(32), .DEPTH(RAM_DEPTH)) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (wa),
        .i_wdata   (wd),
        .i_raddr_a (i_iss.a_addr),
        .i_raddr_b (i_iss.b_addr),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // divisor is the determinant captured when it was written
    kfpv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r1.valid && r1.div),
        .i_num   (a_val),
        .i_den   (r_det),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    // operand stage
    assign a_val = r1.a_mem ? t_word'(rd_a) : r1.a_const;
    assign b_val = r1.b_mem ? t_word'(rd_b) : r1.b_const;
    assign a64   = a_val;
    assign b64   = b_val;

    always_comb begin
        if (r1.mul) begin
            n_p = a_val * b_val;
        end else if (r1.sub) begin
            n_p = a64 - b64;
        end else begin
            n_p = a64 + b64;
        end
    end

    // round, accumulate, saturate
    always_comb begin
        term = r2_mul ? ((r2_p + HALF) >>> FRAC_BITS) : r2_p;
        if (r2_neg) begin
            term = -term;
        end
        acc = r2_first ? term : r_acc + term;
        if (acc > MAXV) begin
            sat = t_word'(32'h7fff_ffff);
        end else if (acc < MINV) begin
            sat = t_word'(32'h8000_0000);
        end else begin
            sat = t_word'(acc[31:0]);
        end
    end

    // write port: accumulator or divider, never both in one cycle
    always_comb begin
        if (div_done) begin
            we = 1'b1;
            wa = r_dwaddr;
            wd = div_q;
        end else begin
            we = r2_valid && r2_last;
            wa = r2_waddr;
            wd = sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1.valid   <= 1'b0;
            r2_valid   <= 1'b0;
            r_det_zero <= 1'b0;
            for (int e = 0; e < STATE_COUNT; e++) begin
                r_est[e] <= '0;
            end
        end else begin
            r1       <= i_iss;
            r2_valid <= r1.valid && !r1.div;
            if (r2_valid && r2_last && r2_det) begin
                r_det_zero <= (sat == '0);
            end
            // estimate lives at the bottom of the memory, mirrored here
            if (we && wa < A_EST + RAM_AW'(STATE_COUNT)) begin
                r_est[3'(wa - A_EST)] <= wd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r2_p     <= n_p;
        r2_mul   <= r1.mul;
        r2_neg   <= r1.neg;
        r2_first <= r1.first;
        r2_last  <= r1.last;
        r2_det   <= r1.det;
        r2_waddr <= r1.waddr;
        r_acc    <= acc;
        if (r1.valid && r1.div) begin
            r_dwaddr <= r1.waddr;
        end
        if (r2_valid && r2_last && r2_det) begin
            r_det <= sat;
        end
    end

    assign o_stat.empty    = !r1.valid && !r2_valid;
    assign o_stat.div_done = div_done;
    assign o_stat.det_zero = r_det_zero;
    assign o_est           = r_est;
endmodule
`default_nettype wire

// File: hw/rtl/kfpv_seq.sv
`default_nettype none
module kfpv_seq
    import kfpv_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_cmd     i_cmd,
    input  wire t_cfg     i_cfg,
    input  wire t_dp_stat i_dp,
    input  wire logic     i_out_free,
    output logic          o_in_ready,
    output t_issue        o_iss,
    output logic          o_fin,
    output logic [1:0]    o_status
);
    typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_DIVWAIT, S_DRAIN, S_FINISH} t_state;

    t_state           r_state;
    logic [4:0]       r_pc;
    logic [CNT_W-1:0] r_i;
    logic [CNT_W-1:0] r_j;
    logic [CNT_W-1:0] r_k;
    logic [1:0]       r_status;
    logic             r_ready;
    logic [30:0]      r_dt;
    logic [MEAS_COUNT-1:0][31:0] r_z;
    logic [30:0]      r_q;
    logic [30:0]      r_r;

    t_uword           w;
    logic [CNT_W-1:0] kmax;
    logic             last_k;
    logic             last_j;
    logic             last_i;
    logic             compute;
    logic [CNT_W-1:0] ar, ac, br, bc;
    logic [CNT_W-1:0] ar2, ac2, br2, bc2;

    function automatic logic [CNT_W-1:0] inc3(logic [CNT_W-1:0] x);
        logic [CNT_W-1:0] y;
        case (x)
            CNT_W'(0): y = CNT_W'(1);
            CNT_W'(1): y = CNT_W'(2);
            default:   y = CNT_W'(0);
        endcase
        return y;
    endfunction

    function automatic t_word cval(t_src src, logic [CNT_W-1:0] r, logic [CNT_W-1:0] c,
                                   logic [30:0] dt, logic [30:0] p0, logic [30:0] q,
                                   logic [30:0] rn, logic [MEAS_COUNT-1:0][31:0] z);
        t_word v;
        case (src)
            SRC_AMAT: begin
                if (r == c) v = ONE_FX;
                else if (r < CNT_W'(3) && c == r + CNT_W'(3)) v = t_word'({1'b0, dt});
                else v = '0;
            end
            SRC_HMAT: begin
                if ((r == CNT_W'(0) && c == CNT_W'(0)) || (r == CNT_W'(1) && c == CNT_W'(1))
                    || (r == CNT_W'(2) && c == CNT_W'(5))) v = ONE_FX;
                else v = '0;
            end
            SRC_IDENT:  v = (r == c) ? ONE_FX : '0;
            SRC_QDIAG:  v = (r == c) ? t_word'({1'b0, q}) : '0;
            SRC_RDIAG:  v = (r == c) ? t_word'({1'b0, rn}) : '0;
            SRC_P0DIAG: v = (r == c) ? t_word'({1'b0, p0}) : '0;
            SRC_Z: begin
                case (r)
                    CNT_W'(0): v = t_word'(z[0]);
                    CNT_W'(1): v = t_word'(z[1]);
                    default:   v = t_word'(z[2]);
                endcase
            end
            default: v = '0;
        endcase
        return v;
    endfunction

    assign w = rom(r_pc);

    always_comb begin
        case (w.kind)
            K_MUL:   kmax = w.m - CNT_W'(1);
            K_COF:   kmax = CNT_W'(1);
            default: kmax = '0;
        endcase
    end

    assign last_k  = r_k == kmax;
    assign last_j  = r_j == w.p - CNT_W'(1);
    assign last_i  = r_i == w.n - CNT_W'(1);
    assign compute = w.kind == K_MUL || w.kind == K_ADD || w.kind == K_SUB
                     || w.kind == K_COF || w.kind == K_DIV;

    // operand coordinates before transposition
    always_comb begin
        case (w.kind)
            K_MUL: begin
                ar = r_i; ac = r_k; br = r_k; bc = r_j;
            end
            K_COF: begin
                // cyclic cofactor: rows i+1, i+2 and columns swapped on the second term
                ar = inc3(r_i);
                br = inc3(inc3(r_i));
                ac = (r_k != '0) ? inc3(inc3(r_j)) : inc3(r_j);
                bc = (r_k != '0) ? inc3(r_j) : inc3(inc3(r_j));
            end
            default: begin
                ar = r_i; ac = r_j; br = r_i; bc = r_j;
            end
        endcase
        ar2 = w.a.tr ? ac : ar;
        ac2 = w.a.tr ? ar : ac;
        br2 = w.b.tr ? bc : br;
        bc2 = w.b.tr ? br : bc;
    end

    always_comb begin
        o_iss.valid   = (r_state == S_ISSUE) && compute;
        o_iss.a_mem   = w.a.src == SRC_MEM;
        o_iss.b_mem   = w.b.src == SRC_MEM;
        o_iss.a_addr  = RAM_AW'(w.a.base + RAM_AW'(ar2) * RAM_AW'(w.a.ld) + RAM_AW'(ac2));
        o_iss.b_addr  = RAM_AW'(w.b.base + RAM_AW'(br2) * RAM_AW'(w.b.ld) + RAM_AW'(bc2));
        o_iss.a_const = cval(w.a.src, ar2, ac2, r_dt, i_cfg.init_cov, r_q, r_r, r_z);
        o_iss.b_const = cval(w.b.src, br2, bc2, r_dt, i_cfg.init_cov, r_q, r_r, r_z);
        o_iss.mul     = w.kind == K_MUL || w.kind == K_COF;
        o_iss.sub     = w.kind == K_SUB;
        o_iss.neg     = w.kind == K_COF && r_k != '0;
        o_iss.first   = r_k == '0;
        o_iss.last    = last_k;
        o_iss.div     = w.kind == K_DIV;
        o_iss.det     = w.det;
        o_iss.waddr   = RAM_AW'(w.cbase + RAM_AW'(r_i) * RAM_AW'(w.cld) + RAM_AW'(r_j));
    end

    assign o_in_ready = r_state == S_IDLE;
    assign o_fin      = (r_state == S_FINISH) && i_out_free;
    assign o_status   = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ready  <= 1'b0;
            r_pc     <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_status <= ST_DONE;
            r_q      <= '0;
            r_r      <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_accept) begin
                        r_dt     <= i_cmd.dt;
                        r_z      <= i_cmd.z;
                        r_status <= ST_DONE;
                        r_i      <= '0;
                        r_j      <= '0;
                        r_k      <= '0;
                        if (i_cmd.cmd == CMD_INIT) begin
                            r_q     <= i_cfg.proc_noise;
                            r_r     <= i_cfg.meas_noise;
                            r_ready <= 1'b1;
                            r_pc    <= PC_INIT;
                            r_state <= S_ISSUE;
                        end else if (!r_ready) begin
                            r_status <= ST_NOT_READY;
                            r_state  <= S_FINISH;
                        end else if (i_cmd.cmd == CMD_PREDICT) begin
                            r_pc    <= PC_PREDICT;
                            r_state <= S_ISSUE;
                        end else if (i_cmd.cmd == CMD_UPDATE) begin
                            r_pc    <= PC_UPDATE;
                            r_state <= S_ISSUE;
                        end else begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_ISSUE: begin
                    case (w.kind)
                        K_JZ: begin
                            if (i_dp.det_zero) begin
                                r_status <= ST_SINGULAR;
                                r_state  <= S_FINISH;
                            end else begin
                                r_pc <= r_pc + 5'd1;
                            end
                        end
                        K_END: r_state <= S_FINISH;
                        K_DIV: r_state <= S_DIVWAIT;
                        default: begin
                            if (!last_k) begin
                                r_k <= r_k + CNT_W'(1);
                            end else begin
                                r_k <= '0;
                                if (!last_j) begin
                                    r_j <= r_j + CNT_W'(1);
                                end else begin
                                    r_j <= '0;
                                    r_i <= r_i + CNT_W'(1);
                                    if (last_i) r_state <= S_DRAIN;
                                end
                            end
                        end
                    endcase
                end
                S_DIVWAIT: begin
                    if (i_dp.div_done) begin
                        if (!last_j) begin
                            r_j     <= r_j + CNT_W'(1);
                            r_state <= S_ISSUE;
                        end else begin
                            r_j <= '0;
                            r_i <= r_i + CNT_W'(1);
                            r_state <= last_i ? S_DRAIN : S_ISSUE;
                        end
                    end
                end
                S_DRAIN: begin
                    if (i_dp.empty) begin
                        r_pc    <= r_pc + 5'd1;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_k     <= '0;
                        r_state <= S_ISSUE;
                    end
                end
                S_FINISH: begin
                    if (i_out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/kalman_filter_pose_velocity.sv
// one command at a time; the next word is taken once the previous command has finished
// the shared multiply-accumulate runs one product a cycle while the sequencer issues; it
// stalls to drain between steps, and the divider takes one gain entry at a time
// commands before init and unknown commands finish without running a program
// reset (synchronous, active low) clears the estimate, the ready flag and the control state;
// the covariance memory is written by init and needs no clearing
`default_nettype none
module kalman_filter_pose_velocity
    import kfpv_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    kfpv_in_if.sink      i_in,
    kfpv_out_if.source   o_res,
    kfpv_cfg_if.sink     i_cfg
);
    // configuration registers, always writable
    t_cfg       r_cfg;

    // sequencer and datapath
    t_cmd       cmd;
    t_issue     iss;
    t_dp_stat   dp_stat;
    t_word      est [STATE_COUNT];
    logic       in_ready;
    logic       fin;
    logic [1:0] status;
    logic       out_free;

    // result word, held while the sink stalls
    logic       r_out_valid;
    logic [1:0] r_out_status;
    t_word      r_out_est [STATE_COUNT];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.init_cov   <= CFG_INIT_COV_RST;
            r_cfg.proc_noise <= CFG_PROC_NOISE_RST;
            r_cfg.meas_noise <= CFG_MEAS_NOISE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_INIT_COV:   r_cfg.init_cov   <= i_cfg.data;
                REG_PROC_NOISE: r_cfg.proc_noise <= i_cfg.data;
                REG_MEAS_NOISE: r_cfg.meas_noise <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // input word into the sequencer
    assign cmd.cmd  = i_in.cmd;
    assign cmd.dt   = i_in.dt;
    assign cmd.z[0] = i_in.meas_x;
    assign cmd.z[1] = i_in.meas_y;
    assign cmd.z[2] = i_in.meas_omega;

    assign i_in.ready = in_ready;

    // finish only into a free output register
    assign out_free = !r_out_valid || o_res.ready;

    kfpv_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (i_in.valid && in_ready),
        .i_cmd      (cmd),
        .i_cfg      (r_cfg),
        .i_dp       (dp_stat),
        .i_out_free (out_free),
        .o_in_ready (in_ready),
        .o_iss      (iss),
        .o_fin      (fin),
        .o_status   (status)
    );

    kfpv_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_iss   (iss),
        .o_stat  (dp_stat),
        .o_est   (est)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_out_status <= status;
            r_out_est    <= est;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.status    = r_out_status;
    assign o_res.est_x     = r_out_est[0];
    assign o_res.est_y     = r_out_est[1];
    assign o_res.est_theta = r_out_est[2];
    assign o_res.est_vx    = r_out_est[3];
    assign o_res.est_vy    = r_out_est[4];
    assign o_res.est_omega = r_out_est[5];
endmodule
`default_nettype wire
